### rtl/nfba_pkg.sv
// Shared types and constants for the next-fit block allocator.
// No dependencies; every other file of the block imports this package.
package nfba_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int DATA_W   = 24;

  // Item kinds carried in the input tuser.
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  // Block count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // Command to the block table for one cycle of its single port.
  typedef struct packed {
    logic rd;       // read size and mark at the address
    logic wr_size;  // write the size at the address
    logic wr_mark;  // write the occupied mark at the address
    logic mark;     // mark value to write
  } tbl_cmd_t;

endpackage

### rtl/nfba_table.sv
// Block table: size memory and occupied-mark memory behind one shared port.
// Depends on nfba_pkg for the command struct.
module nfba_table #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  nfba_pkg::tbl_cmd_t    cmd,
  input  logic [IDX_W-1:0]      addr,
  input  logic [SIZE_BITS-1:0]  wsize,
  output logic [SIZE_BITS-1:0]  rsize,
  output logic                  rmark
);
  import nfba_pkg::*;

  logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
  logic                 mark_mem [MAX_BLOCKS];

  // Single port: one read or write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.wr_size) begin
      size_mem[addr] <= wsize;
    end
    if (cmd.wr_mark) begin
      mark_mem[addr] <= cmd.mark;
    end
    if (cmd.rd) begin
      rsize <= size_mem[addr];
      rmark <= mark_mem[addr];
    end
  end

endmodule

### rtl/nfba_ctrl.sv
// Sequencer of the allocator: loads, restarts, the next-fit scan and the result register.
// Depends on nfba_pkg; drives the port of nfba_table.
module nfba_ctrl #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nfba_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nfba_pkg::ACTION_W-1:0] action,
  input  logic [nfba_pkg::INDEX_W-1:0]  block_index,
  input  logic [nfba_pkg::SIZE_W-1:0]   size,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          placed,
  output logic [nfba_pkg::INDEX_W-1:0]  placed_block,
  output logic [nfba_pkg::SIZE_W-1:0]   size_left,
  output nfba_pkg::tbl_cmd_t            tbl_cmd,
  output logic [IDX_W-1:0]              tbl_addr,
  output logic [SIZE_BITS-1:0]          tbl_wsize,
  input  logic [SIZE_BITS-1:0]          tbl_rsize,
  input  logic                          tbl_rmark
);
  import nfba_pkg::*;

  localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

  state_t               state;
  logic [IDX_W-1:0]     clr_addr;
  logic [CNT_W-1:0]     search_start;
  logic [COUNT_W-1:0]   block_count;
  logic [SIZE_W-1:0]    want;
  logic [CNT_W-1:0]     n_use;
  logic [CNT_W-1:0]     remaining;
  logic [IDX_W-1:0]     scan_addr;
  logic [IDX_W-1:0]     rd_addr;
  logic                 pending;

  logic [31:0]          count_full;
  logic [CNT_W-1:0]     n_cfg;
  logic [IDX_W-1:0]     first_addr;
  logic [EXT_W-1:0]     load_idx_ext;
  logic                 load_ok;
  logic [CMP_W-1:0]     load_ext;
  logic [CMP_W-1:0]     diff_full;
  logic [SIZE_BITS-1:0] new_size;
  logic [CMP_W-1:0]     left_ext;
  logic [EXT_W-1:0]     hit_idx_ext;
  logic                 hit;
  logic                 finish;
  logic                 slot_free;
  logic                 scan_wrap;
  logic                 clr_last;

  // Blocks in use, saturated to the table depth, and where the scan begins.
  assign count_full = 32'(block_count);
  assign n_cfg      = (count_full > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(count_full);
  assign first_addr = (search_start < n_cfg) ? search_start[IDX_W-1:0] : '0;

  // Load address check and size truncation.
  assign load_idx_ext = EXT_W'(block_index);
  assign load_ok      = (32'(block_index) < MAX_BLOCKS);
  assign load_ext     = CMP_W'(size);

  // Evaluation of the entry whose read data is now registered.
  assign hit         = pending && !tbl_rmark && (CMP_W'(tbl_rsize) >= CMP_W'(want));
  assign diff_full   = CMP_W'(tbl_rsize) - CMP_W'(want);
  assign new_size    = diff_full[SIZE_BITS-1:0];
  assign left_ext    = CMP_W'(new_size);
  assign hit_idx_ext = EXT_W'(rd_addr);
  assign finish      = hit || (remaining == '0);
  assign slot_free   = !m_tvalid || m_tready;
  assign scan_wrap   = (CNT_W'(scan_addr) + CNT_W'(1)) == n_use;
  assign clr_last    = (clr_addr == IDX_W'(MAX_BLOCKS - 1));

  assign s_tready = (state == S_IDLE);

  // Table port: clearing writes, load writes, scan reads and the grant write.
  always_comb begin
    tbl_cmd   = '0;
    tbl_addr  = scan_addr;
    tbl_wsize = load_ext[SIZE_BITS-1:0];
    case (state)
      S_CLEAR: begin
        tbl_cmd.wr_mark = 1'b1;
        tbl_addr        = clr_addr;
      end
      S_IDLE: begin
        if (s_tvalid && (action == ACT_LOAD) && load_ok) begin
          tbl_cmd.wr_size = 1'b1;
          tbl_cmd.wr_mark = 1'b1;
          tbl_addr        = load_idx_ext[IDX_W-1:0];
        end
      end
      S_SCAN: begin
        if (finish) begin
          if (slot_free && hit) begin
            tbl_cmd.wr_size = 1'b1;
            tbl_cmd.wr_mark = 1'b1;
            tbl_cmd.mark    = 1'b1;
            tbl_addr        = rd_addr;
            tbl_wsize       = new_size;
          end
        end else begin
          tbl_cmd.rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State, scan registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      search_start <= '0;
      block_count  <= COUNT_RESET;
      pending      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      // A taken result frees the register unless a new one is loaded now.
      if (m_tvalid && m_tready && !((state == S_SCAN) && finish)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_last ? '0 : clr_addr + IDX_W'(1);
          if (clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            if (action == ACT_REQUEST) begin
              want      <= size;
              n_use     <= n_cfg;
              remaining <= n_cfg;
              scan_addr <= first_addr;
              pending   <= 1'b0;
              state     <= S_SCAN;
            end else if (action == ACT_RESTART) begin
              search_start <= '0;
              clr_addr     <= '0;
              state        <= S_CLEAR;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            // Hold the read data until the result register is free.
            if (slot_free) begin
              m_tvalid     <= 1'b1;
              placed       <= hit;
              placed_block <= hit ? hit_idx_ext[INDEX_W-1:0] : '0;
              size_left    <= hit ? left_ext[SIZE_W-1:0] : '0;
              if (hit) begin
                search_start <= CNT_W'(rd_addr) + CNT_W'(1);
              end
              pending <= 1'b0;
              state   <= S_IDLE;
            end
          end else begin
            rd_addr   <= scan_addr;
            scan_addr <= scan_wrap ? '0 : scan_addr + IDX_W'(1);
            remaining <= remaining - CNT_W'(1);
            pending   <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/next_fit_block_allocator.sv
// Next-fit block allocator. A load is written to the table in the cycle it is taken. A request
// scans the blocks in use, n of them, from the entry after the last grant until a block fits or
// all n have been read; the single table port reads one entry per cycle. A restart runs a
// mark clearing pass over all MAX_BLOCKS entries. After reset (synchronous, active high) the
// same clearing pass runs before the first input transfer is taken; the configuration port
// is live throughout.
module next_fit_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Block count register.
  input  logic                          cfg_we,
  input  logic [nfba_pkg::COUNT_W-1:0]  cfg_wdata,
  // Input items.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nfba_pkg::DATA_W-1:0]   s_tdata,   // block_index[3:0], size[19:4], zero pad
  input  logic [nfba_pkg::ACTION_W-1:0] s_tuser,   // action[1:0]
  // Results.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nfba_pkg::DATA_W-1:0]   m_tdata,   // placed_block[3:0], size_left[19:4], zero pad
  output logic                          m_tuser    // placed
);
  import nfba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  tbl_cmd_t             tbl_cmd;
  logic [IDX_W-1:0]     tbl_addr;
  logic [SIZE_BITS-1:0] tbl_wsize;
  logic [SIZE_BITS-1:0] tbl_rsize;
  logic                 tbl_rmark;
  logic [INDEX_W-1:0]   placed_block;
  logic [SIZE_W-1:0]    size_left;

  // Sequencer and result register.
  nfba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .action       (s_tuser),
    .block_index  (s_tdata[INDEX_W-1:0]),
    .size         (s_tdata[INDEX_W+SIZE_W-1:INDEX_W]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .placed       (m_tuser),
    .placed_block (placed_block),
    .size_left    (size_left),
    .tbl_cmd      (tbl_cmd),
    .tbl_addr     (tbl_addr),
    .tbl_wsize    (tbl_wsize),
    .tbl_rsize    (tbl_rsize),
    .tbl_rmark    (tbl_rmark)
  );

  // Block sizes and occupied marks.
  nfba_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk   (clk),
    .cmd   (tbl_cmd),
    .addr  (tbl_addr),
    .wsize (tbl_wsize),
    .rsize (tbl_rsize),
    .rmark (tbl_rmark)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {(DATA_W - INDEX_W - SIZE_W)'(0), size_left, placed_block};

endmodule
